/* hw/rtl/hts_pkg.sv */
// ----------------------------------------------------------------------------
// hts_pkg
// Shared constants and the stage metadata type for the heightmap triangle sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hts_pkg;

   localparam int GRID_SIDE_DEF = 129;
   localparam int TILES_W       = 8;
   localparam int TILES_RESET   = 128;
   localparam int FRAC_W        = 8;
   localparam int HEIGHT_W      = 16;
   localparam int DIFF_W        = HEIGHT_W + 1;
   localparam int WEIGHT_W      = FRAC_W + 1;
   localparam int OUT_W         = 24;
   localparam int POS_W         = 17;
   localparam int INDEX_W       = 15;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // travels alongside each request through the pipeline
   typedef struct packed {
      logic              valid;
      logic              query;
      logic              in_map;
      logic [FRAC_W-1:0] fx;
      logic [FRAC_W-1:0] fz;
   } hts_meta_type;

endpackage

/* hw/rtl/hts_if.sv */
// ----------------------------------------------------------------------------
// hts_if
// Request and response channels of the heightmap triangle sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hts_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic [hts_pkg::INDEX_W-1:0]         load_index;
   logic signed [hts_pkg::HEIGHT_W-1:0] load_height;
   logic signed [hts_pkg::POS_W-1:0]    pos_x;
   logic signed [hts_pkg::POS_W-1:0]    pos_z;

   modport source (
      output valid, command, load_index, load_height, pos_x, pos_z,
      input  ready
   );
   modport sink (
      input  valid, command, load_index, load_height, pos_x, pos_z,
      output ready
   );
endinterface

interface hts_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             in_map;
   logic signed [hts_pkg::OUT_W-1:0] height_out;

   modport source (
      output valid, in_map, height_out,
      input  ready
   );
   modport sink (
      input  valid, in_map, height_out,
      output ready
   );
endinterface

/* hw/rtl/hts_addr.sv */
// ----------------------------------------------------------------------------
// hts_addr
// Two stages: cell and fraction decode of a request, then row base address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hts_addr #(
   parameter int GRID_SIDE = hts_pkg::GRID_SIDE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic [hts_pkg::TILES_W-1:0]         tiles,
   input  logic                                in_valid,
   input  logic                                in_command,
   input  logic [hts_pkg::INDEX_W-1:0]         in_load_index,
   input  logic signed [hts_pkg::HEIGHT_W-1:0] in_load_height,
   input  logic signed [hts_pkg::POS_W-1:0]    in_pos_x,
   input  logic signed [hts_pkg::POS_W-1:0]    in_pos_z,
   output hts_pkg::hts_meta_type               out_meta,
   output logic [hts_pkg::TILES_W-1:0]         out_col,
   output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] out_row_base,
   output logic                                out_load_we,
   output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] out_load_addr,
   output logic signed [hts_pkg::HEIGHT_W-1:0] out_load_height
);

   localparam int STORE_DEPTH = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int TW          = hts_pkg::TILES_W;
   localparam int FW          = hts_pkg::FRAC_W;
   localparam int CW          = hts_pkg::POS_W + 1;

   logic [TW:0]   side;
   logic [TW-1:0] half;
   logic [CW-1:0] cx;
   logic [CW-1:0] cz;
   logic [CW-FW-1:0] nx_raw;
   logic [CW-FW-1:0] nz_raw;
   logic          x_ok;
   logic          z_ok;

   hts_pkg::hts_meta_type            s1_meta_in, s1_meta_ff;
   logic [TW-1:0]                    s1_nx_in, s1_nx_ff;
   logic [TW-1:0]                    s1_nz_in, s1_nz_ff;
   logic                             s1_load_ok_in, s1_load_ok_ff;
   logic [ADDR_W-1:0]                s1_load_addr_in, s1_load_addr_ff;
   logic signed [hts_pkg::HEIGHT_W-1:0] s1_load_height_ff;

   logic [2*TW:0]                    row_prod;
   hts_pkg::hts_meta_type            s2_meta_ff;
   logic [TW-1:0]                    s2_col_ff;
   logic [ADDR_W-1:0]                s2_row_base_in, s2_row_base_ff;
   logic                             s2_load_we_in, s2_load_we_ff;
   logic [ADDR_W-1:0]                s2_load_addr_ff;
   logic signed [hts_pkg::HEIGHT_W-1:0] s2_load_height_ff;

   // stage 1: offset by half the side, floor to cell, range check
   always_comb begin
      side   = {1'b0, tiles} + {{TW{1'b0}}, 1'b1};
      half   = side[TW:1];
      cx     = {in_pos_x[hts_pkg::POS_W-1], in_pos_x} + CW'({half, {FW{1'b0}}});
      cz     = {in_pos_z[hts_pkg::POS_W-1], in_pos_z} + CW'({half, {FW{1'b0}}});
      nx_raw = cx[CW-1:FW];
      nz_raw = cz[CW-1:FW];
      x_ok   = !nx_raw[CW-FW-1] && (nx_raw[CW-FW-2:0] < (CW-FW-1)'(tiles));
      z_ok   = !nz_raw[CW-FW-1] && (nz_raw[CW-FW-2:0] < (CW-FW-1)'(tiles));

      s1_meta_in.valid  = in_valid;
      s1_meta_in.query  = (in_command == hts_pkg::CMD_QUERY);
      s1_meta_in.in_map = x_ok && z_ok;
      s1_meta_in.fx     = cx[FW-1:0];
      s1_meta_in.fz     = cz[FW-1:0];
      s1_nx_in          = s1_meta_in.in_map ? nx_raw[TW-1:0] : '0;
      s1_nz_in          = s1_meta_in.in_map ? nz_raw[TW-1:0] : '0;
      s1_load_ok_in     = 32'(in_load_index) < 32'(STORE_DEPTH);
      s1_load_addr_in   = ADDR_W'(in_load_index);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_meta_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_meta_ff <= s1_meta_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_nx_ff          <= s1_nx_in;
         s1_nz_ff          <= s1_nz_in;
         s1_load_ok_ff     <= s1_load_ok_in;
         s1_load_addr_ff   <= s1_load_addr_in;
         s1_load_height_ff <= in_load_height;
      end
   end

   // stage 2: row base = row * side
   always_comb begin
      row_prod       = s1_nz_ff * side;
      s2_row_base_in = ADDR_W'(row_prod);
      s2_load_we_in  = s1_meta_ff.valid && !s1_meta_ff.query && s1_load_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_meta_ff.valid <= 1'b0;
         s2_load_we_ff    <= 1'b0;
      end else if (advance) begin
         s2_meta_ff    <= s1_meta_ff;
         s2_load_we_ff <= s2_load_we_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_col_ff         <= s1_nx_ff;
         s2_row_base_ff    <= s2_row_base_in;
         s2_load_addr_ff   <= s1_load_addr_ff;
         s2_load_height_ff <= s1_load_height_ff;
      end
   end

   assign out_meta        = s2_meta_ff;
   assign out_col         = s2_col_ff;
   assign out_row_base    = s2_row_base_ff;
   assign out_load_we     = s2_load_we_ff;
   assign out_load_addr   = s2_load_addr_ff;
   assign out_load_height = s2_load_height_ff;

endmodule

/* hw/rtl/hts_store.sv */
// ----------------------------------------------------------------------------
// hts_store
// Height grid held in two copies; each copy serves one row of the cell
// through two read ports, so all four corners are read in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hts_store #(
   parameter int GRID_SIDE = hts_pkg::GRID_SIDE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic [hts_pkg::TILES_W-1:0]         tiles,
   input  hts_pkg::hts_meta_type               in_meta,
   input  logic [hts_pkg::TILES_W-1:0]         in_col,
   input  logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] in_row_base,
   input  logic                                in_load_we,
   input  logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] in_load_addr,
   input  logic signed [hts_pkg::HEIGHT_W-1:0] in_load_height,
   output hts_pkg::hts_meta_type               out_meta,
   output logic signed [hts_pkg::HEIGHT_W-1:0] out_h0,
   output logic signed [hts_pkg::HEIGHT_W-1:0] out_h1,
   output logic signed [hts_pkg::HEIGHT_W-1:0] out_h2,
   output logic signed [hts_pkg::HEIGHT_W-1:0] out_h3
);

   localparam int STORE_DEPTH = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int HW          = hts_pkg::HEIGHT_W;

   logic signed [HW-1:0] mem_lo [STORE_DEPTH];
   logic signed [HW-1:0] mem_hi [STORE_DEPTH];

   logic [ADDR_W-1:0] addr_lo0;
   logic [ADDR_W-1:0] addr_lo1;
   logic [ADDR_W-1:0] addr_hi0;
   logic [ADDR_W-1:0] addr_hi1;

   hts_pkg::hts_meta_type s3_meta_ff;
   logic signed [HW-1:0]  h0_ff, h1_ff, h2_ff, h3_ff;

   always_comb begin
      addr_lo0 = in_row_base + ADDR_W'(in_col);
      addr_lo1 = addr_lo0 + ADDR_W'(1);
      addr_hi0 = addr_lo0 + ADDR_W'({1'b0, tiles} + 9'd1);
      addr_hi1 = addr_hi0 + ADDR_W'(1);
   end

   always_ff @(posedge clock) begin
      if (advance && in_load_we) begin
         mem_lo[in_load_addr] <= in_load_height;
         mem_hi[in_load_addr] <= in_load_height;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         h0_ff <= mem_lo[addr_lo0];
         h2_ff <= mem_lo[addr_lo1];
         h1_ff <= mem_hi[addr_hi0];
         h3_ff <= mem_hi[addr_hi1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_meta_ff.valid <= 1'b0;
      end else if (advance) begin
         s3_meta_ff <= in_meta;
      end
   end

   assign out_meta = s3_meta_ff;
   assign out_h0   = h0_ff;
   assign out_h1   = h1_ff;
   assign out_h2   = h2_ff;
   assign out_h3   = h3_ff;

endmodule

/* hw/rtl/hts_interp.sv */
// ----------------------------------------------------------------------------
// hts_interp
// Triangle select and operand setup, then weighted sum into the response
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hts_interp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  hts_pkg::hts_meta_type               in_meta,
   input  logic signed [hts_pkg::HEIGHT_W-1:0] in_h0,
   input  logic signed [hts_pkg::HEIGHT_W-1:0] in_h1,
   input  logic signed [hts_pkg::HEIGHT_W-1:0] in_h2,
   input  logic signed [hts_pkg::HEIGHT_W-1:0] in_h3,
   output logic                                out_valid,
   output logic                                out_in_map,
   output logic signed [hts_pkg::OUT_W-1:0]    out_height
);

   localparam int HW   = hts_pkg::HEIGHT_W;
   localparam int DW   = hts_pkg::DIFF_W;
   localparam int WW   = hts_pkg::WEIGHT_W;
   localparam int FW   = hts_pkg::FRAC_W;
   localparam int PW   = DW + WW + 1;
   localparam int SW   = PW + 1;
   localparam int OW   = hts_pkg::OUT_W;

   logic                 lower;
   logic [WW-1:0]        one_q8;
   logic [WW-1:0]        fx_w;
   logic [WW-1:0]        fz_w;

   hts_pkg::hts_meta_type s4_meta_ff;
   logic signed [HW-1:0] s4_base_in, s4_base_ff;
   logic signed [DW-1:0] s4_da_in, s4_da_ff;
   logic signed [DW-1:0] s4_db_in, s4_db_ff;
   logic [WW-1:0]        s4_wa_in, s4_wa_ff;
   logic [WW-1:0]        s4_wb_in, s4_wb_ff;

   logic signed [PW-1:0] prod_a;
   logic signed [PW-1:0] prod_b;
   logic [SW-1:0]        sum;

   logic                 out_valid_in, out_valid_ff;
   logic                 out_in_map_ff;
   logic [OW-1:0]        out_height_in, out_height_ff;

   // stage 4: lower-left triangle when fx + fz < 1.0
   always_comb begin
      one_q8 = {1'b1, {FW{1'b0}}};
      fx_w   = {1'b0, in_meta.fx};
      fz_w   = {1'b0, in_meta.fz};
      lower  = (fx_w + fz_w) < one_q8;
      if (lower) begin
         s4_base_in = in_h0;
         s4_da_in   = DW'(in_h1) - DW'(in_h0);
         s4_db_in   = DW'(in_h2) - DW'(in_h0);
         s4_wa_in   = fz_w;
         s4_wb_in   = fx_w;
      end else begin
         s4_base_in = in_h3;
         s4_da_in   = DW'(in_h1) - DW'(in_h3);
         s4_db_in   = DW'(in_h2) - DW'(in_h3);
         s4_wa_in   = one_q8 - fx_w;
         s4_wb_in   = one_q8 - fz_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_meta_ff.valid <= 1'b0;
      end else if (advance) begin
         s4_meta_ff <= in_meta;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_base_ff <= s4_base_in;
         s4_da_ff   <= s4_da_in;
         s4_db_ff   <= s4_db_in;
         s4_wa_ff   <= s4_wa_in;
         s4_wb_ff   <= s4_wb_in;
      end
   end

   // stage 5: base * 1.0 + da * wa + db * wb
   always_comb begin
      prod_a = s4_da_ff * $signed({1'b0, s4_wa_ff});
      prod_b = s4_db_ff * $signed({1'b0, s4_wb_ff});
      sum    = {{(SW-HW-FW){s4_base_ff[HW-1]}}, s4_base_ff, {FW{1'b0}}}
             + {prod_a[PW-1], prod_a}
             + {prod_b[PW-1], prod_b};
      out_valid_in  = s4_meta_ff.valid && s4_meta_ff.query;
      out_height_in = s4_meta_ff.in_map ? sum[OW-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_in_map_ff <= s4_meta_ff.in_map;
         out_height_ff <= out_height_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_in_map = out_in_map_ff;
   assign out_height = $signed(out_height_ff);

endmodule

/* hw/rtl/heightmap_triangle_sampler_core.sv */
// ----------------------------------------------------------------------------
// heightmap_triangle_sampler_core
// Stages: decode, row base, grid read, triangle setup, then weighted sum into
//   the response register.
// Throughput: one request per cycle; the whole pipeline holds while the
//   response register is full and not taken.
// Reset: synchronous; clears the pipeline and sets tiles_ff to 128.
//   The height grid is not cleared and reads are defined only once written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heightmap_triangle_sampler_core #(
   parameter int GRID_SIDE = hts_pkg::GRID_SIDE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic [hts_pkg::TILES_W-1:0] csr_write_data,
   hts_req_if.sink                     req_chan,
   hts_rsp_if.source                   rsp_chan
);

   localparam int STORE_DEPTH = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int TW          = hts_pkg::TILES_W;
   localparam int TILES_MAX   = (GRID_SIDE - 1 > 255) ? 255 : GRID_SIDE - 1;
   localparam int TILES_INIT  =
      (hts_pkg::TILES_RESET > TILES_MAX) ? TILES_MAX : hts_pkg::TILES_RESET;

   logic          advance;
   logic [TW-1:0] tiles_in, tiles_ff;

   hts_pkg::hts_meta_type               s2_meta;
   logic [TW-1:0]                       s2_col;
   logic [ADDR_W-1:0]                   s2_row_base;
   logic                                s2_load_we;
   logic [ADDR_W-1:0]                   s2_load_addr;
   logic signed [hts_pkg::HEIGHT_W-1:0] s2_load_height;

   hts_pkg::hts_meta_type               s3_meta;
   logic signed [hts_pkg::HEIGHT_W-1:0] h0, h1, h2, h3;

   always_comb begin
      if (csr_write_data == '0) begin
         tiles_in = TW'(1);
      end else if (csr_write_data > TW'(TILES_MAX)) begin
         tiles_in = TW'(TILES_MAX);
      end else begin
         tiles_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tiles_ff <= TW'(TILES_INIT);
      end else if (csr_write_en) begin
         tiles_ff <= tiles_in;
      end
   end

   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   hts_addr #(
      .GRID_SIDE (GRID_SIDE)
   ) u_addr (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .tiles           (tiles_ff),
      .in_valid        (req_chan.valid),
      .in_command      (req_chan.command),
      .in_load_index   (req_chan.load_index),
      .in_load_height  (req_chan.load_height),
      .in_pos_x        (req_chan.pos_x),
      .in_pos_z        (req_chan.pos_z),
      .out_meta        (s2_meta),
      .out_col         (s2_col),
      .out_row_base    (s2_row_base),
      .out_load_we     (s2_load_we),
      .out_load_addr   (s2_load_addr),
      .out_load_height (s2_load_height)
   );

   hts_store #(
      .GRID_SIDE (GRID_SIDE)
   ) u_store (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .tiles          (tiles_ff),
      .in_meta        (s2_meta),
      .in_col         (s2_col),
      .in_row_base    (s2_row_base),
      .in_load_we     (s2_load_we),
      .in_load_addr   (s2_load_addr),
      .in_load_height (s2_load_height),
      .out_meta       (s3_meta),
      .out_h0         (h0),
      .out_h1         (h1),
      .out_h2         (h2),
      .out_h3         (h3)
   );

   hts_interp u_interp (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_meta    (s3_meta),
      .in_h0      (h0),
      .in_h1      (h1),
      .in_h2      (h2),
      .in_h3      (h3),
      .out_valid  (rsp_chan.valid),
      .out_in_map (rsp_chan.in_map),
      .out_height (rsp_chan.height_out)
   );

`ifndef SYNTHESIS
   a_tiles_range: assert property (@(posedge clock) disable iff (reset)
      tiles_ff != '0 && tiles_ff <= TW'(TILES_MAX))
      else $error("active tile count out of range");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.in_map |-> rsp_chan.height_out == '0)
      else $error("outside query with nonzero height");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> rsp_chan.valid && $stable(s3_meta) && $stable(rsp_chan.height_out))
      else $error("pipeline moved during stall");

   a_load_no_map: assert property (@(posedge clock) disable iff (reset)
      s2_load_we |-> s2_meta.valid && !s2_meta.query)
      else $error("grid write from a query");
`endif

endmodule

/* verif/heightmap_triangle_sampler_core_test.sv */
// ----------------------------------------------------------------------------
// heightmap_triangle_sampler_core_test
// Self-checking bench for the triangle height sampler. Streams height loads
// and position queries through the request channel, keeps a shadow height
// grid and tile count, and checks every response against the predicted
// triangle interpolation. Runs several tile-count settings with random
// idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heightmap_triangle_sampler_core_test;

   localparam int GRID_SIDE_DEF   = hts_pkg::GRID_SIDE_DEF;
   localparam int FRAC_W          = hts_pkg::FRAC_W;
   localparam int INDEX_W         = hts_pkg::INDEX_W;
   localparam int HEIGHT_W        = hts_pkg::HEIGHT_W;
   localparam int POS_W           = hts_pkg::POS_W;
   localparam int OUT_W           = hts_pkg::OUT_W;
   localparam int TILES_W         = hts_pkg::TILES_W;
   localparam int TILES_RESET     = hts_pkg::TILES_RESET;
   localparam int STORE_DEPTH     = GRID_SIDE_DEF * GRID_SIDE_DEF;
   localparam int UNIT            = 1 << FRAC_W;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int NUM_PHASES      = 6;
   localparam int SETTLE_CYCLES   = 10;
   localparam int CYCLE_LIMIT     = 200000;

   typedef struct {
      logic                       command;
      logic [INDEX_W-1:0]         load_index;
      logic signed [HEIGHT_W-1:0] load_height;
      logic signed [POS_W-1:0]    pos_x;
      logic signed [POS_W-1:0]    pos_z;
   } sampler_req_type;

   typedef struct {
      logic                    in_map;
      logic signed [OUT_W-1:0] height_out;
   } sample_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [TILES_W-1:0]   csr_write_data;

   hts_req_if req_if ();
   hts_rsp_if rsp_if ();

   heightmap_triangle_sampler_core dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if)
   );

   // shadow state
   logic signed [HEIGHT_W-1:0] height_mem [STORE_DEPTH];
   logic [TILES_W-1:0]         model_tiles;
   bit                         corner_loaded [STORE_DEPTH];

   sampler_req_type pending_requests [$];
   sample_type      expected_samples [$];
   sampler_req_type bus_req;

   int error_count    = 0;
   int cycle_count    = 0;
   int items_queued   = 0;
   int send_idle_pct  = 0;
   int take_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void queue_request(sampler_req_type item);
      pending_requests.insert(pending_requests.size(), item);
   endfunction

   function automatic void queue_sample(sample_type s);
      expected_samples.insert(expected_samples.size(), s);
   endfunction

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------
   function automatic int grid_tiles();
      int t;
      t = model_tiles;
      if (t < 1) t = 1;
      if (t > GRID_SIDE_DEF - 1) t = GRID_SIDE_DEF - 1;
      return t;
   endfunction

   function automatic int map_offset();
      return ((grid_tiles() + 1) / 2) * UNIT;
   endfunction

   function automatic bit cell_in_map(int nx, int nz);
      return nx >= 0 && nz >= 0 && nx < grid_tiles() && nz < grid_tiles();
   endfunction

   function automatic sample_type predict_sample(sampler_req_type r);
      int         side, sx, sz, nx, nz, fx, fz, h0, h1, h2, h3, y;
      sample_type s;
      side = grid_tiles() + 1;
      sx = int'(r.pos_x) + map_offset();
      sz = int'(r.pos_z) + map_offset();
      nx = sx >>> FRAC_W;
      nz = sz >>> FRAC_W;
      s.in_map = 1'b0;
      s.height_out = '0;
      if (cell_in_map(nx, nz)) begin
         fx = sx & (UNIT - 1);
         fz = sz & (UNIT - 1);
         h0 = height_mem[nz * side + nx];
         h1 = height_mem[(nz + 1) * side + nx];
         h2 = height_mem[nz * side + nx + 1];
         h3 = height_mem[(nz + 1) * side + nx + 1];
         if (fx + fz < UNIT)
            y = h0 * UNIT + (h1 - h0) * fz + (h2 - h0) * fx;
         else
            y = h3 * UNIT + (h1 - h3) * (UNIT - fx) + (h2 - h3) * (UNIT - fz);
         s.in_map = 1'b1;
         s.height_out = y[OUT_W-1:0];
      end
      return s;
   endfunction

   function automatic void apply_request(sampler_req_type r);
      if (r.command == hts_pkg::CMD_LOAD) begin
         if (r.load_index < STORE_DEPTH) height_mem[r.load_index] = r.load_height;
      end else begin
         queue_sample(predict_sample(r));
      end
   endfunction

   // ---------------------------------------------------------------------
   // request generation
   // ---------------------------------------------------------------------
   function automatic void push_load(int idx, logic signed [HEIGHT_W-1:0] h);
      sampler_req_type item;
      item.command     = hts_pkg::CMD_LOAD;
      item.load_index  = INDEX_W'(idx);
      item.load_height = h;
      item.pos_x       = POS_W'($urandom);
      item.pos_z       = POS_W'($urandom);
      queue_request(item);
      if (idx < STORE_DEPTH) begin
         corner_loaded[idx] = 1'b1;
         items_queued++;
      end
   endfunction

   // loads any corner not yet written so an in-map query never reads garbage
   function automatic void push_query(int px, int pz);
      sampler_req_type item;
      int              nx, nz, side, idx;
      side = grid_tiles() + 1;
      nx = (px + map_offset()) >>> FRAC_W;
      nz = (pz + map_offset()) >>> FRAC_W;
      if (cell_in_map(nx, nz)) begin
         for (int dz = 0; dz < 2; dz++) begin
            for (int dx = 0; dx < 2; dx++) begin
               idx = (nz + dz) * side + nx + dx;
               if (!corner_loaded[idx]) push_load(idx, HEIGHT_W'($urandom));
            end
         end
      end
      item.command     = hts_pkg::CMD_QUERY;
      item.load_index  = INDEX_W'($urandom);
      item.load_height = HEIGHT_W'($urandom);
      item.pos_x       = POS_W'(px);
      item.pos_z       = POS_W'(pz);
      queue_request(item);
      items_queued++;
   endfunction

   function automatic int pick_frac();
      case ($urandom_range(9))
         0: return 0;
         1: return UNIT - 1;
         2: return UNIT / 2;
         default: return $urandom_range(UNIT - 1);
      endcase
   endfunction

   // reload some corners of one cell, then query inside it
   function automatic void cell_visit();
      int nx, nz, side, nq;
      side = grid_tiles() + 1;
      nx = $urandom_range(grid_tiles() - 1);
      nz = $urandom_range(grid_tiles() - 1);
      for (int dz = 0; dz < 2; dz++) begin
         for (int dx = 0; dx < 2; dx++) begin
            if ($urandom_range(2) == 0)
               push_load((nz + dz) * side + nx + dx, HEIGHT_W'($urandom));
         end
      end
      nq = $urandom_range(3, 1);
      for (int q = 0; q < nq; q++) begin
         push_query(nx * UNIT + pick_frac() - map_offset(),
                    nz * UNIT + pick_frac() - map_offset());
      end
   endfunction

   function automatic void random_item();
      int                      roll, ex, ez, idx;
      int                      edges [4];
      logic signed [POS_W-1:0] rx, rz;
      roll = $urandom_range(99);
      if (roll < 60) begin
         cell_visit();
      end else if (roll < 75) begin
         // cells on and just past the map border
         edges = '{-1, 0, grid_tiles() - 1, grid_tiles()};
         ex = edges[$urandom_range(3)];
         ez = int'($urandom_range(grid_tiles() + 1)) - 1;
         if ($urandom_range(1)) begin
            idx = ex;
            ex = ez;
            ez = idx;
         end
         push_query(ex * UNIT + $urandom_range(UNIT - 1) - map_offset(),
                    ez * UNIT + $urandom_range(UNIT - 1) - map_offset());
      end else if (roll < 88) begin
         rx = POS_W'($urandom);
         rz = POS_W'($urandom);
         push_query(rx, rz);
      end else begin
         if ($urandom_range(3) == 0) idx = $urandom_range((1 << INDEX_W) - 1);
         else idx = $urandom_range(STORE_DEPTH - 1);
         push_load(idx, HEIGHT_W'($urandom));
      end
   endfunction

   function automatic void directed_requests();
      int base;
      base = -map_offset();
      push_load(0, 16'sh8000);
      push_load(1, 16'sh7FFF);
      push_load(GRID_SIDE_DEF, 16'sh7FFF);
      push_load(GRID_SIDE_DEF + 1, 16'sh8000);
      push_load(STORE_DEPTH, 16'sh1234);
      push_load((1 << INDEX_W) - 1, -16'sd1);
      push_query(base, base);
      push_query(base + 255, base + 255);
      push_query(base + 128, base + 128);
      push_query(base + 127, base + 128);
      push_query(base + 255, base);
      push_load(STORE_DEPTH - GRID_SIDE_DEF - 2, 16'sh7FFF);
      push_load(STORE_DEPTH - GRID_SIDE_DEF - 1, 16'sh8000);
      push_load(STORE_DEPTH - 2, 16'sh8000);
      push_load(STORE_DEPTH - 1, 16'sh7FFF);
      push_query(map_offset() - 1, map_offset() - 1);
      push_query(map_offset() - UNIT, map_offset() - UNIT);
      // just below zero after the offset: floor must land in cell -1
      push_query(base - 1, 0);
      push_query(-100, base - 1);
      push_query(map_offset(), 0);
      push_query(-65536, 65535);
      push_query(65535, -65536);
   endfunction

   // ---------------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      logic next_valid;
      if (reset) begin
         req_if.valid       <= 1'b0;
         req_if.command     <= hts_pkg::CMD_LOAD;
         req_if.load_index  <= '0;
         req_if.load_height <= '0;
         req_if.pos_x       <= '0;
         req_if.pos_z       <= '0;
      end else begin
         next_valid = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            apply_request(bus_req);
            next_valid = 1'b0;
         end
         if (!next_valid && pending_requests.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            bus_req = pending_requests.pop_front();
            req_if.command     <= bus_req.command;
            req_if.load_index  <= bus_req.load_index;
            req_if.load_height <= bus_req.load_height;
            req_if.pos_x       <= bus_req.pos_x;
            req_if.pos_z       <= bus_req.pos_z;
            next_valid = 1'b1;
         end
         req_if.valid <= next_valid;
      end
   end

   // ---------------------------------------------------------------------
   // response monitor
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_samples
      sample_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_samples.size() == 0) begin
               $error("unexpected response: in_map %0b height_out %0d",
                      rsp_if.in_map, rsp_if.height_out);
               error_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_if.in_map !== want.in_map) begin
                  $error("in_map mismatch: expected %0b, actual %0b",
                         want.in_map, rsp_if.in_map);
                  error_count++;
               end
               if (rsp_if.height_out !== want.height_out) begin
                  $error("height_out mismatch: expected %0d, actual %0d",
                         want.height_out, rsp_if.height_out);
                  error_count++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= take_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // sequencing
   // ---------------------------------------------------------------------
   task automatic write_tiles(logic [TILES_W-1:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      model_tiles = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // loads give no response, so allow the pipeline to drain after the last one
   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_if.valid || expected_samples.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : run_phases
      logic [TILES_W-1:0] phase_tiles [NUM_PHASES];
      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_write_data     = '0;
      model_tiles        = TILES_W'(TILES_RESET);
      phase_tiles = '{8'd128, 8'd1, 8'd255, 8'd0, 8'd2, 8'd127};
      phase_tiles[4] = TILES_W'($urandom_range(126, 2));
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase / 2)
            0: begin
               send_idle_pct  = 6;
               take_stall_pct = 87;
            end
            1: begin
               send_idle_pct  = 87;
               take_stall_pct = 6;
            end
            default: begin
               send_idle_pct  = 0;
               take_stall_pct = 0;
            end
         endcase
         write_tiles(phase_tiles[phase]);
         items_queued = 0;
         if (phase == 0) directed_requests();
         while (items_queued < ITEMS_PER_PHASE) random_item();
         wait_idle();
      end
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/hts_pkg.sv
hw/rtl/hts_if.sv
hw/rtl/hts_addr.sv
hw/rtl/hts_store.sv
hw/rtl/hts_interp.sv
hw/rtl/heightmap_triangle_sampler_core.sv
verif/heightmap_triangle_sampler_core_test.sv
